/* design/cpt_pkg.sv */
// Shared types, widths and codes for the closest point on triangle block.
// No dependencies.
package cpt_pkg;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int EW = CW + 1;
    localparam int DW = 2 * EW + 2;
    localparam int HW = DW / 2;
    localparam int BW = 2 * DW + 4;
    localparam int QW = FB + 1;
    localparam int QD = 4;
    localparam int QAW = 2;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;
    typedef logic signed [DW-1:0] dot_t;
    typedef logic signed [BW-1:0] big_t;
    typedef logic [BW-1:0] ubig_t;
    typedef logic [QW-1:0] wgt_t;

    localparam wgt_t ONE_Q = wgt_t'(1) << FB;

    typedef enum logic [2:0] {
        SEL_INT,
        SEL_S,
        SEL_T,
        SEL_SC,
        SEL_TC
    } sel_t;

    typedef struct packed {
        edge_t [2:0] v0;
        edge_t [2:0] e1;
        edge_t [2:0] e2;
    } geo_t;

    typedef struct packed {
        big_t num_a;
        big_t den_a;
        big_t num_b;
        big_t den_b;
        sel_t sel;
        geo_t geo;
    } job_t;

endpackage

/* design/closest_point_on_triangle_3d.sv */
// Closest point on a 3D triangle: top level joining front, queue and back.
// Throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined multipliers and
// the pipelined ratio units; a four-entry queue lets the front run while the output stalls.
// Reset: synchronous active-low aresetn clears all valid bits and queue pointers.
// Depends on cpt_pkg, cpt_front, cpt_fifo, cpt_back.
module closest_point_on_triangle_3d
    import cpt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_vert0_x,
    input  coord_t s_vert0_y,
    input  coord_t s_vert0_z,
    input  coord_t s_vert1_x,
    input  coord_t s_vert1_y,
    input  coord_t s_vert1_z,
    input  coord_t s_vert2_x,
    input  coord_t s_vert2_y,
    input  coord_t s_vert2_z,
    input  coord_t s_query_x,
    input  coord_t s_query_y,
    input  coord_t s_query_z,
    output logic   m_valid,
    input  logic   m_ready,
    output wgt_t   m_bary_s,
    output wgt_t   m_bary_t,
    output coord_t m_near_x,
    output coord_t m_near_y,
    output coord_t m_near_z
);

    job_t         fr_job;
    job_t         q_head;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    coord_t [2:0] near;

    cpt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .vert0    ({s_vert0_z, s_vert0_y, s_vert0_x}),
        .vert1    ({s_vert1_z, s_vert1_y, s_vert1_x}),
        .vert2    ({s_vert2_z, s_vert2_y, s_vert2_x}),
        .query    ({s_query_z, s_query_y, s_query_x}),
        .q_full   (q_full),
        .push     (q_push),
        .job      (fr_job)
    );

    cpt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_job  (fr_job),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    cpt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .bary_s    (m_bary_s),
        .bary_t    (m_bary_t),
        .near      (near)
    );

    assign m_near_x = near[0];
    assign m_near_y = near[1];
    assign m_near_z = near[2];

endmodule

/* design/cpt_front.sv */
// Front pipeline: edge vectors, dot products, wide products and region classification.
// Depends on cpt_pkg.
module cpt_front
    import cpt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  coord_t [2:0] vert0,
    input  coord_t [2:0] vert1,
    input  coord_t [2:0] vert2,
    input  coord_t [2:0] query,
    input  logic        q_full,
    output logic        push,
    output job_t        job
);

    typedef logic signed [2*EW-1:0] sq_t;
    typedef logic signed [2*HW+1:0] pp_t;
    typedef struct packed {
        pp_t ll;
        pp_t lh;
        pp_t hl;
        pp_t hh;
    } pp4_t;

    function automatic pp4_t split_mul(dot_t x, dot_t y);
        logic signed [HW-1:0] xh;
        logic signed [HW-1:0] yh;
        logic signed [HW:0]   xl;
        logic signed [HW:0]   yl;
        pp4_t r;
        xh = $signed(x[DW-1:HW]);
        yh = $signed(y[DW-1:HW]);
        xl = $signed({1'b0, x[HW-1:0]});
        yl = $signed({1'b0, y[HW-1:0]});
        r.ll = xl * yl;
        r.lh = xl * yh;
        r.hl = xh * yl;
        r.hh = xh * yh;
        return r;
    endfunction

    logic        en;
    logic [7:1]  v_reg;
    geo_t        geo_reg [1:6];
    edge_t       ep_reg [3];
    sq_t         p_reg [5][3];
    dot_t        dot3_reg [5];
    dot_t        dot4_reg [5];
    dot_t        dot5_reg [5];
    dot_t        dot6_reg [5];
    pp4_t        pp_reg [6];
    big_t        prod_reg [6];
    big_t        sn_reg;
    big_t        tn_reg;
    big_t        det_reg;
    big_t        dn_reg;
    big_t        acbb;
    job_t        job_reg;
    job_t        job_next;

    assign en       = !(v_reg[7] && q_full);
    assign in_ready = en;
    assign push     = v_reg[7] && !q_full;
    assign job      = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                geo_reg[1].v0[k] <= EW'($signed(vert0[k]));
                geo_reg[1].e1[k] <= EW'($signed(vert1[k])) - EW'($signed(vert0[k]));
                geo_reg[1].e2[k] <= EW'($signed(vert2[k])) - EW'($signed(vert0[k]));
                ep_reg[k]        <= EW'($signed(vert0[k])) - EW'($signed(query[k]));
            end
            for (int i = 2; i <= 6; i++) begin
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                p_reg[0][k] <= geo_reg[1].e1[k] * geo_reg[1].e1[k];
                p_reg[1][k] <= geo_reg[1].e1[k] * geo_reg[1].e2[k];
                p_reg[2][k] <= geo_reg[1].e2[k] * geo_reg[1].e2[k];
                p_reg[3][k] <= geo_reg[1].e1[k] * ep_reg[k];
                p_reg[4][k] <= geo_reg[1].e2[k] * ep_reg[k];
            end
            for (int i = 0; i < 5; i++) begin
                dot3_reg[i] <= DW'(p_reg[i][0]) + DW'(p_reg[i][1]) + DW'(p_reg[i][2]);
            end
            dot4_reg <= dot3_reg;
            pp_reg[0] <= split_mul(dot3_reg[1], dot3_reg[4]);
            pp_reg[1] <= split_mul(dot3_reg[2], dot3_reg[3]);
            pp_reg[2] <= split_mul(dot3_reg[1], dot3_reg[3]);
            pp_reg[3] <= split_mul(dot3_reg[0], dot3_reg[4]);
            pp_reg[4] <= split_mul(dot3_reg[0], dot3_reg[2]);
            pp_reg[5] <= split_mul(dot3_reg[1], dot3_reg[1]);
            dot5_reg <= dot4_reg;
            for (int i = 0; i < 6; i++) begin
                prod_reg[i] <= (big_t'(pp_reg[i].hh) <<< (2 * HW))
                             + ((big_t'(pp_reg[i].lh) + big_t'(pp_reg[i].hl)) <<< HW)
                             + big_t'(pp_reg[i].ll);
            end
            dot6_reg <= dot5_reg;
            sn_reg   <= prod_reg[0] - prod_reg[1];
            tn_reg   <= prod_reg[2] - prod_reg[3];
            det_reg  <= (acbb[BW-1] ? -acbb : acbb) + big_t'(1);
            dn_reg   <= big_t'(dot5_reg[0]) + big_t'(dot5_reg[2])
                      - big_t'(dot5_reg[1]) - big_t'(dot5_reg[1]);
            job_reg  <= job_next;
        end
    end

    assign acbb = prod_reg[4] - prod_reg[5];

    always_comb begin
        big_t a, b, c, d, e, t0, t1;
        a = big_t'(dot6_reg[0]);
        b = big_t'(dot6_reg[1]);
        c = big_t'(dot6_reg[2]);
        d = big_t'(dot6_reg[3]);
        e = big_t'(dot6_reg[4]);
        t0 = '0;
        t1 = '0;
        job_next       = '0;
        job_next.geo   = geo_reg[6];
        job_next.sel   = SEL_INT;
        if ((sn_reg + tn_reg) <= det_reg) begin
            if (sn_reg[BW-1]) begin
                if (tn_reg[BW-1] && d[BW-1]) begin
                    job_next.num_a = -d;
                    job_next.den_a = a;
                    job_next.sel   = SEL_S;
                end else begin
                    job_next.num_a = -e;
                    job_next.den_a = c;
                    job_next.sel   = SEL_T;
                end
            end else if (tn_reg[BW-1]) begin
                job_next.num_a = -d;
                job_next.den_a = a;
                job_next.sel   = SEL_S;
            end else begin
                job_next.num_a = sn_reg;
                job_next.den_a = det_reg;
                job_next.num_b = tn_reg;
                job_next.den_b = det_reg;
                job_next.sel   = SEL_INT;
            end
        end else if (sn_reg[BW-1]) begin
            t0 = b + d;
            t1 = c + e;
            if (t1 > t0) begin
                job_next.num_a = t1 - t0;
                job_next.den_a = dn_reg;
                job_next.sel   = SEL_SC;
            end else if (t1 <= big_t'(0)) begin
                job_next.num_a = big_t'(1);
                job_next.den_a = '0;
                job_next.sel   = SEL_T;
            end else begin
                job_next.num_a = -e;
                job_next.den_a = c;
                job_next.sel   = SEL_T;
            end
        end else if (tn_reg[BW-1]) begin
            t0 = b + e;
            t1 = a + d;
            if (t1 > t0) begin
                job_next.num_a = t1 - t0;
                job_next.den_a = dn_reg;
                job_next.sel   = SEL_TC;
            end else if (t1 <= big_t'(0)) begin
                job_next.num_a = big_t'(1);
                job_next.den_a = '0;
                job_next.sel   = SEL_S;
            end else begin
                job_next.num_a = -d;
                job_next.den_a = a;
                job_next.sel   = SEL_S;
            end
        end else begin
            job_next.num_a = (c + e) - (b + d);
            job_next.den_a = dn_reg;
            job_next.sel   = SEL_SC;
        end
    end

endmodule

/* design/cpt_fifo.sv */
// Short queue of classified jobs between the front and back pipelines.
// Depends on cpt_pkg.
module cpt_fifo
    import cpt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t wr_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    job_t           mem_reg [QD];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;

    assign full  = (cnt_reg == (QAW+1)'(QD));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

/* design/cpt_div.sv */
// Pipelined clamped ratio unit, one quotient bit per stage.
// Depends on cpt_pkg.
module cpt_div
    import cpt_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  big_t num,
    input  big_t den,
    output wgt_t quo
);

    ubig_t         rem_reg  [0:FB-1];
    ubig_t         den_reg  [0:FB-1];
    logic [FB-1:0] qb_reg   [0:FB];
    logic          zero_reg [0:FB];
    logic          one_reg  [0:FB];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= ubig_t'(num);
            den_reg[0]  <= ubig_t'(den);
            qb_reg[0]   <= '0;
            zero_reg[0] <= (num <= big_t'(0));
            one_reg[0]  <= (num >= den);
        end
    end

    for (genvar i = 1; i <= FB; i++) begin : g_step
        ubig_t dbl;
        logic  ge;
        assign dbl = {rem_reg[i-1][BW-2:0], 1'b0};
        assign ge  = (dbl >= den_reg[i-1]);

        always_ff @(posedge aclk) begin
            if (en) begin
                qb_reg[i]   <= {qb_reg[i-1][FB-2:0], ge};
                zero_reg[i] <= zero_reg[i-1];
                one_reg[i]  <= one_reg[i-1];
            end
        end

        if (i < FB) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= ge ? (dbl - den_reg[i-1]) : dbl;
                    den_reg[i] <= den_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        priority if (zero_reg[FB]) begin
            quo = '0;
        end else if (one_reg[FB]) begin
            quo = ONE_Q;
        end else begin
            quo = {1'b0, qb_reg[FB]};
        end
    end

endmodule

/* design/cpt_back.sv */
// Back pipeline: ratio units, weight selection, closest point and output register.
// Depends on cpt_pkg and cpt_div.
module cpt_back
    import cpt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output wgt_t        bary_s,
    output wgt_t        bary_t,
    output coord_t [2:0] near
);

    localparam int AW = EW + QW + 3;
    typedef logic signed [EW+QW:0] mp_t;
    typedef logic signed [AW-1:0]  acc_t;
    localparam acc_t SAT_HI = acc_t'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam acc_t SAT_LO = -SAT_HI - acc_t'(1);

    logic        back_en;
    logic        bv_reg [0:FB];
    sel_t        sel_reg [0:FB];
    geo_t        geo_reg [0:FB];
    wgt_t        qa;
    wgt_t        qb;
    wgt_t        s_w;
    wgt_t        t_w;
    logic        mv_reg;
    wgt_t        ms_reg;
    wgt_t        mt_reg;
    edge_t       mv0_reg [3];
    mp_t         m1_reg [3];
    mp_t         m2_reg [3];
    logic        out_v_reg;
    wgt_t        os_reg;
    wgt_t        ot_reg;
    coord_t      near_reg [3];

    assign back_en   = !out_v_reg || out_ready;
    assign pop       = back_en && !empty;
    assign out_valid = out_v_reg;
    assign bary_s    = os_reg;
    assign bary_t    = ot_reg;
    assign near      = {near_reg[2], near_reg[1], near_reg[0]};

    cpt_div u_div_a (
        .aclk (aclk),
        .en   (back_en),
        .num  (head.num_a),
        .den  (head.den_a),
        .quo  (qa)
    );

    cpt_div u_div_b (
        .aclk (aclk),
        .en   (back_en),
        .num  (head.num_b),
        .den  (head.den_b),
        .quo  (qb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= FB; i++) begin
                bv_reg[i] <= 1'b0;
            end
            mv_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (back_en) begin
            bv_reg[0] <= !empty;
            for (int i = 1; i <= FB; i++) begin
                bv_reg[i] <= bv_reg[i-1];
            end
            mv_reg    <= bv_reg[FB];
            out_v_reg <= mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            sel_reg[0] <= head.sel;
            geo_reg[0] <= head.geo;
            for (int i = 1; i <= FB; i++) begin
                sel_reg[i] <= sel_reg[i-1];
                geo_reg[i] <= geo_reg[i-1];
            end
        end
    end

    always_comb begin
        unique case (sel_reg[FB])
            SEL_INT: begin
                s_w = qa;
                t_w = qb;
            end
            SEL_S: begin
                s_w = qa;
                t_w = '0;
            end
            SEL_T: begin
                s_w = '0;
                t_w = qa;
            end
            SEL_SC: begin
                s_w = qa;
                t_w = ONE_Q - qa;
            end
            SEL_TC: begin
                s_w = ONE_Q - qa;
                t_w = qa;
            end
            default: begin
                s_w = '0;
                t_w = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            ms_reg <= s_w;
            mt_reg <= t_w;
            for (int k = 0; k < 3; k++) begin
                mv0_reg[k] <= geo_reg[FB].v0[k];
                m1_reg[k]  <= geo_reg[FB].e1[k] * $signed({1'b0, s_w});
                m2_reg[k]  <= geo_reg[FB].e2[k] * $signed({1'b0, t_w});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            acc_t acc;
            acc_t hi;
            os_reg <= ms_reg;
            ot_reg <= mt_reg;
            for (int k = 0; k < 3; k++) begin
                acc = (acc_t'(mv0_reg[k]) <<< FB) + acc_t'(m1_reg[k]) + acc_t'(m2_reg[k])
                    + (acc_t'(1) <<< (FB - 1));
                hi  = acc >>> FB;
                priority if (hi > SAT_HI) begin
                    near_reg[k] <= CW'(SAT_HI);
                end else if (hi < SAT_LO) begin
                    near_reg[k] <= CW'(SAT_LO);
                end else begin
                    near_reg[k] <= CW'(hi);
                end
            end
        end
    end

endmodule

/* design/cpt_checker.sv */
// Port-level checks for the closest point block, bound to the top level.
// Depends on cpt_pkg and closest_point_on_triangle_3d.
module cpt_checker
    import cpt_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input wgt_t m_bary_s,
    input wgt_t m_bary_t
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_bary_s) && $stable(m_bary_t))
        else $error("result weights changed while stalled");

    a_weight_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_bary_s} + {1'b0, m_bary_t}) <= {1'b0, ONE_Q})
        else $error("weights exceed one");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not cleared by reset");

endmodule

bind closest_point_on_triangle_3d cpt_checker u_cpt_checker (.*);

/* dv/tb_closest_point_on_triangle_3d.sv */
// Testbench for closest_point_on_triangle_3d: directed, random and backpressure
// tests checked against an exact wide-integer predictor. Depends on cpt_pkg.
`timescale 1ns / 100ps

module tb_closest_point_on_triangle_3d;
    import cpt_pkg::*;

    typedef logic signed [199:0] wide_t;

    typedef struct {
        wgt_t   s;
        wgt_t   t;
        coord_t x;
        coord_t y;
        coord_t z;
    } near_pt_t;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coord_t s_c [12];
    logic   m_valid;
    logic   m_ready;
    wgt_t   m_bary_s;
    wgt_t   m_bary_t;
    coord_t m_near_x;
    coord_t m_near_y;
    coord_t m_near_z;

    near_pt_t expected_pts [$];
    int       mismatches;
    int       rx_mode;
    int       rx_cycle;
    int       hold_left;
    bit       hold_req;

    closest_point_on_triangle_3d DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_vert0_x (s_c[0]),
        .s_vert0_y (s_c[1]),
        .s_vert0_z (s_c[2]),
        .s_vert1_x (s_c[3]),
        .s_vert1_y (s_c[4]),
        .s_vert1_z (s_c[5]),
        .s_vert2_x (s_c[6]),
        .s_vert2_y (s_c[7]),
        .s_vert2_z (s_c[8]),
        .s_query_x (s_c[9]),
        .s_query_y (s_c[10]),
        .s_query_z (s_c[11]),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_bary_s  (m_bary_s),
        .m_bary_t  (m_bary_t),
        .m_near_x  (m_near_x),
        .m_near_y  (m_near_y),
        .m_near_z  (m_near_z)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic wide_t clamp_ratio(wide_t num, wide_t den);
        if (num <= 0) return 0;
        if (num >= den) return 65536;
        return (num <<< FB) / den;
    endfunction

    function automatic wide_t edge_weight(wide_t x, wide_t len);
        if (x >= 0) return 0;
        return clamp_ratio(-x, len);
    endfunction

    function automatic near_pt_t predict_point(input coord_t p [12]);
        wide_t    v0 [3];
        wide_t    e1 [3];
        wide_t    e2 [3];
        wide_t    ep [3];
        wide_t    a, b, c, d, e, sn, tn, det, dn, t0, t1, s, t, acc;
        wide_t    pos [3];
        near_pt_t r;
        for (int k = 0; k < 3; k++) begin
            v0[k] = p[k];
            e1[k] = wide_t'(p[3 + k]) - v0[k];
            e2[k] = wide_t'(p[6 + k]) - v0[k];
            ep[k] = v0[k] - wide_t'(p[9 + k]);
        end
        a = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
        b = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
        c = e2[0] * e2[0] + e2[1] * e2[1] + e2[2] * e2[2];
        d = e1[0] * ep[0] + e1[1] * ep[1] + e1[2] * ep[2];
        e = e2[0] * ep[0] + e2[1] * ep[1] + e2[2] * ep[2];
        sn = b * e - c * d;
        tn = b * d - a * e;
        det = a * c - b * b;
        if (det < 0) det = -det;
        det = det + 1;
        dn = (a + c) - (b + b);
        if (sn + tn <= det) begin
            if (sn < 0) begin
                if (tn < 0 && d < 0) begin
                    t = 0;
                    s = edge_weight(d, a);
                end else begin
                    s = 0;
                    t = edge_weight(e, c);
                end
            end else if (tn < 0) begin
                t = 0;
                s = edge_weight(d, a);
            end else begin
                s = clamp_ratio(sn, det);
                t = clamp_ratio(tn, det);
            end
        end else if (sn < 0) begin
            t0 = b + d;
            t1 = c + e;
            if (t1 > t0) begin
                s = clamp_ratio(t1 - t0, dn);
                t = 65536 - s;
            end else begin
                s = 0;
                t = (t1 <= 0) ? 65536 : edge_weight(e, c);
            end
        end else if (tn < 0) begin
            t0 = b + e;
            t1 = a + d;
            if (t1 > t0) begin
                t = clamp_ratio(t1 - t0, dn);
                s = 65536 - t;
            end else begin
                t = 0;
                s = (t1 <= 0) ? 65536 : edge_weight(d, a);
            end
        end else begin
            s = clamp_ratio((c + e) - (b + d), dn);
            t = 65536 - s;
        end
        for (int k = 0; k < 3; k++) begin
            acc = (v0[k] <<< FB) + e1[k] * s + e2[k] * t + 32768;
            acc = acc >>> FB;
            if (acc > 200'sd2147483647) acc = 200'sd2147483647;
            if (acc < -200'sd2147483648) acc = -200'sd2147483648;
            pos[k] = acc;
        end
        r.s = s[QW-1:0];
        r.t = t[QW-1:0];
        r.x = pos[0][CW-1:0];
        r.y = pos[1][CW-1:0];
        r.z = pos[2][CW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Predict each input transaction as it is accepted.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) expected_pts.push_back(predict_point(s_c));
    end

    // Check each output transaction against the oldest prediction.
    always @(posedge aclk) begin
        near_pt_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pts.size() == 0) begin
                report_mismatch("unexpected", 0, 0);
            end else begin
                w = expected_pts.pop_front();
                if (m_bary_s !== w.s) report_mismatch("bary_s", m_bary_s, w.s);
                if (m_bary_t !== w.t) report_mismatch("bary_t", m_bary_t, w.t);
                if (m_near_x !== w.x) report_mismatch("near_x", m_near_x, w.x);
                if (m_near_y !== w.y) report_mismatch("near_y", m_near_y, w.y);
                if (m_near_z !== w.z) report_mismatch("near_z", m_near_z, w.z);
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
        if (hold_req && hold_left == 0) begin
            hold_req = 1'b0;
            hold_left <= 300;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_item(input coord_t p [12]);
        bit ok;
        s_valid <= 1'b1;
        for (int k = 0; k < 12; k++) s_c[k] <= p[k];
        do begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
        end while (!ok);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    function automatic coord_t rand_coord(int scale);
        case (scale)
            0: return coord_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            1: return coord_t'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_tri(coord_t v0x, coord_t v0y, coord_t v0z,
                            coord_t v1x, coord_t v1y, coord_t v1z,
                            coord_t v2x, coord_t v2y, coord_t v2z,
                            coord_t qx, coord_t qy, coord_t qz);
        coord_t p [12];
        p = '{v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, qx, qy, qz};
        send_item(p);
    endtask

    task automatic test_directed_geometry();
        coord_t one, mx, mn;
        one = 32'sh0001_0000;
        mx = 32'sh7FFF_FFFF;
        mn = -32'sh8000_0000;
        send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx);
        send_tri(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, mn, mx);
        send_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mn);
        // interior, each edge and each corner (some corners twice) of a right triangle with legs along x and y
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, one, one, 3 * one);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, 2 * one, -one, one);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, -one, 2 * one, -one);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, 3 * one, 3 * one, 0);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, -one, -one, one);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, 6 * one, -one, 0);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, -one, 6 * one, 0);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, 9 * one, -2 * one, 0);
        send_tri(0, 0, 0, 4 * one, 0, 0, 0, 4 * one, 0, -2 * one, 9 * one, 0);
        // query on each vertex
        send_tri(one, 2 * one, 3, -one, 5, 7 * one, 9, -3 * one, one, one, 2 * one, 3);
        send_tri(one, 2 * one, 3, -one, 5, 7 * one, 9, -3 * one, one, -one, 5, 7 * one);
        send_tri(one, 2 * one, 3, -one, 5, 7 * one, 9, -3 * one, one, 9, -3 * one, one);
        // collapsed triangles: a point, a segment, coincident v1 and v2; then a tiny triangle
        send_tri(one, one, one, one, one, one, one, one, one, -one, 3 * one, 0);
        send_tri(0, 0, 0, 2 * one, 0, 0, 4 * one, 0, 0, 5 * one, one, 0);
        send_tri(0, 0, 0, 2 * one, one, 0, 2 * one, one, 0, 3 * one, 3 * one, one);
        send_tri(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0);
        // v1 equal to v0, with v0 and v2 at opposite ends of the coordinate range
        send_tri(mx, mx, mx, mx, mx, mx, mn, mn, mn, 0, 0, 0);
    endtask

    task automatic test_random_pairs(int count);
        coord_t p [12];
        int     scale;
        int     burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            scale = $urandom_range(0, 9);
            scale = (scale < 6) ? 0 : (scale < 8) ? 1 : 2;
            for (int k = 0; k < 12; k++) p[k] = rand_coord(scale);
            case ($urandom_range(0, 9))
                0: for (int k = 0; k < 3; k++) p[9 + k] = p[3 * $urandom_range(0, 2) + k];
                1: for (int k = 0; k < 3; k++) p[6 + k] = p[3 + k];
                2: for (int k = 0; k < 3; k++) p[3 + k] = p[k];
                default: ;
            endcase
            send_item(p);
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            end else begin
                burst--;
            end
        end
    endtask

    task automatic test_output_backpressure(int count);
        coord_t p [12];
        @(negedge aclk);
        hold_req = 1'b1;
        @(posedge aclk);
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 12; k++) p[k] = rand_coord(n % 3);
            send_item(p);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        for (int k = 0; k < 12; k++) s_c[k] = '0;
        mismatches = 0;
        rx_mode = 0;
        rx_cycle = 0;
        hold_left = 0;
        hold_req = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_geometry();
        test_random_pairs(235);
        test_output_backpressure(60);
        test_random_pairs(235);
        s_valid <= 1'b0;
        while (expected_pts.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && expected_pts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
